// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define LKCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define LKCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lkcd_pkg.sv -----
package lkcd_pkg;

  localparam int KEY_W       = 64;
  localparam int SLOT_W      = 3;
  localparam int OCC_W       = 4;
  localparam int CAP_W       = 4;
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_USED_W  = 1 + SLOT_W + 1 + OCC_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam int OUT_HIT_POS  = 0;
  localparam int OUT_SLOT_LO  = 1;
  localparam int OUT_EVICT_POS = OUT_SLOT_LO + SLOT_W;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd5;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/lkcd_ram.sv -----
module lkcd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lkcd_ctrl.sv -----
module lkcd_ctrl import lkcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t sts,
  output ctrl_cmd_t  ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    ctl        = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lkcd_dpath.sv -----
module lkcd_dpath import lkcd_pkg::*; #(
  parameter int MAX_ENTRIES = 8,
  parameter int KEY_BITS = 64,
  localparam int IW = $clog2(MAX_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           ctl,
  output dp_status_t          sts,
  input  logic                in_command,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic                cfg_wr_en,
  input  logic [CAP_W-1:0]    cfg_wr_data,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_hit,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_evicted,
  output logic [OCC_W-1:0]    out_occupancy
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = ((CW > CAP_W) ? CW : CAP_W) + 1;
  localparam logic [IW:0] SCAN_END = (IW + 1)'(MAX_ENTRIES);
  localparam logic [EW-1:0] MAX_EXT = EW'(MAX_ENTRIES);

  logic [CAP_W-1:0]    cap_r;
  cmd_t                cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [IW:0]         cnt_r;
  logic                chk_en_r;
  logic [IW-1:0]       chk_idx_r;
  logic                found_r, free_r, any_r;
  logic [IW-1:0]       best_rank_r, best_slot_r, free_slot_r, worst_rank_r, worst_slot_r;
  logic                valid_r   [MAX_ENTRIES];
  logic                valid_nxt [MAX_ENTRIES];
  logic [IW-1:0]       rank_r    [MAX_ENTRIES];
  logic [IW-1:0]       rank_nxt  [MAX_ENTRIES];
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r;
  logic                out_hit_r, out_evicted_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [OCC_W-1:0]    out_occ_r;

  logic                scan_issue;
  logic [KEY_BITS-1:0] ram_rdata;
  logic                key_eq, chk_valid;
  logic [IW-1:0]       chk_rank;
  logic [EW-1:0]       cap_ext, eff_cap, count_ext;
  logic                room, do_hit, do_fill, do_evict, do_promote, ram_we;
  logic [IW-1:0]       tgt_slot;
  logic [31:0]         slot_w, occ_w;

  lkcd_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_keys (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tgt_slot),
    .wr_data (key_r),
    .rd_en   (scan_issue),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (ram_rdata)
  );

  assign scan_issue = ctl.scan && (cnt_r != SCAN_END);
  assign key_eq     = (ram_rdata == key_r);
  assign chk_valid  = valid_r[chk_idx_r];
  assign chk_rank   = rank_r[chk_idx_r];

  // capacity 0 acts as 1, above MAX_ENTRIES as MAX_ENTRIES
  assign cap_ext   = EW'(cap_r);
  assign count_ext = EW'(count_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > MAX_EXT) begin
      eff_cap = MAX_EXT;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign room       = (count_ext < eff_cap);
  assign do_hit     = (cmd_r == CMD_LOOKUP) && found_r;
  assign do_fill    = (cmd_r == CMD_INSERT) && room && free_r;
  assign do_evict   = (cmd_r == CMD_INSERT) && !do_fill && any_r;
  assign do_promote = ctl.commit && (do_hit || do_fill || do_evict);
  assign ram_we     = ctl.commit && (do_fill || do_evict);

  always_comb begin
    if (do_hit) begin
      tgt_slot = best_slot_r;
    end else if (do_fill) begin
      tgt_slot = free_slot_r;
    end else if (do_evict) begin
      tgt_slot = worst_slot_r;
    end else begin
      tgt_slot = '0;
    end
  end

  // hit: only entries more recent than the hit move back; insert: all other valid entries move
  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
    end
    if (do_promote) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if ((IW'(i) != tgt_slot) && valid_r[i] &&
            (!do_hit || (rank_r[i] < best_rank_r))) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      rank_nxt[tgt_slot] = '0;
      if (do_fill) begin
        valid_nxt[tgt_slot] = 1'b1;
        count_nxt           = count_r + 1'b1;
      end
    end
  end

  assign slot_w = 32'(tgt_slot);
  assign occ_w  = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAPACITY_RESET;
      cnt_r       <= SCAN_END;
      chk_en_r    <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      any_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (ctl.start) begin
        cnt_r    <= '0;
        chk_en_r <= 1'b0;
        found_r  <= 1'b0;
        free_r   <= 1'b0;
        any_r    <= 1'b0;
      end else begin
        if (scan_issue) begin
          cnt_r <= cnt_r + 1'b1;
        end
        chk_en_r <= scan_issue;
        if (chk_en_r) begin
          if (chk_valid && key_eq && (!found_r || (chk_rank < best_rank_r))) begin
            found_r     <= 1'b1;
            best_rank_r <= chk_rank;
            best_slot_r <= chk_idx_r;
          end
          if (!chk_valid && !free_r) begin
            free_r      <= 1'b1;
            free_slot_r <= chk_idx_r;
          end
          if (chk_valid && (!any_r || (chk_rank > worst_rank_r))) begin
            any_r        <= 1'b1;
            worst_rank_r <= chk_rank;
            worst_slot_r <= chk_idx_r;
          end
        end
      end
      count_r <= count_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_r[i] <= valid_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= cnt_r[IW-1:0];
    if (ctl.start) begin
      cmd_r <= cmd_t'(in_command);
      key_r <= in_key;
    end
    if (ctl.commit) begin
      out_hit_r     <= do_hit;
      out_evicted_r <= do_evict;
      out_slot_r    <= slot_w[SLOT_W-1:0];
      out_occ_r     <= occ_w[OCC_W-1:0];
    end
  end

  assign sts.scan_done = (cnt_r == SCAN_END) && !chk_en_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid    = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_slot      = out_slot_r;
  assign out_evicted   = out_evicted_r;
  assign out_occupancy = out_occ_r;

endmodule

// ----- rtl/lru_key_cache_directory_core.sv -----
// Channel   Dir  Ports                         Contents
// in_       in   tvalid/tready/tdata/tuser     one lookup or insert request
// out_      out  tvalid/tready/tdata           one result per request
// cfg_      in   wr_en/wr_data                 capacity register
//
// Between one acceptance and the next the core scans all MAX_ENTRIES
// entries, reading the key RAM one entry per cycle.
// The result sits in an output register; a new request is taken while it waits.
// A stalled output holds the commit of the following request, not its scan.
// Synchronous active-low reset empties the directory and sets capacity to 5.
module lru_key_cache_directory_core import lkcd_pkg::*; #(
  parameter int MAX_ENTRIES = 8,
  parameter int KEY_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // hit, slot, evicted, occupancy, zero pad
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data
);

  ctrl_cmd_t         ctl;
  dp_status_t        sts;
  logic              out_hit, out_evicted;
  logic [SLOT_W-1:0] out_slot;
  logic [OCC_W-1:0]  out_occupancy;

  lkcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  lkcd_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_command    (in_tuser[0]),
    .in_key        (in_tdata[KEY_BITS-1:0]),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_hit       (out_hit),
    .out_slot      (out_slot),
    .out_evicted   (out_evicted),
    .out_occupancy (out_occupancy)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_occupancy, out_evicted, out_slot, out_hit};

endmodule

// ----- rtl/lkcd_checker.sv -----
`include "assert_macros.svh"

module lkcd_checker import lkcd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // a request is worked on alone: no second one right behind it
  `LKCD_ASSERT(a_one_at_a_time, in_acc |=> !in_tready, "request taken while busy")

  // the scan lies between acceptance and result
  `LKCD_ASSERT(a_no_instant_result, in_acc |=> !$rose(out_tvalid), "result too early")

  // a result never reports a hit and an eviction together
  `LKCD_ASSERT(a_hit_excl_evict,
    out_tvalid |-> !(out_tdata[OUT_HIT_POS] && out_tdata[OUT_EVICT_POS]),
    "hit and evicted together")

  `LKCD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind lru_key_cache_directory_core lkcd_checker u_lkcd_checker (.*);

// ----- verif/tb_lru_key_cache_directory_core.sv -----
module tb_lru_key_cache_directory_core;
  import lkcd_pkg::*;

  localparam int DIR_DEPTH     = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 24;
  localparam int POOL_SIZE     = 12;

  typedef enum {REQ_ITEM, CAP_WRITE, DRAIN_WAIT} pend_kind_t;

  typedef struct {
    pend_kind_t       kind;
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic [CAP_W-1:0] cap;
  } pend_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [OCC_W-1:0]  occ;
  } dir_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]       cfg_wr_data = '0;

  pend_t       pend_q[$];
  dir_result_t result_q[$];
  int          n_open = 0;
  int          n_err = 0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  int          quiet_run = 0;
  logic        calm = 1'b0;

  // directory mirror
  logic [KEY_W-1:0] dir_key [DIR_DEPTH];
  logic             dir_live[DIR_DEPTH];
  int               dir_age [DIR_DEPTH];
  int               dir_fill;
  logic [CAP_W-1:0] dir_cap;

  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  lru_key_cache_directory_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void clear_directory();
    for (int i = 0; i < DIR_DEPTH; i++) begin
      dir_key[i]  = '0;
      dir_live[i] = 1'b0;
      dir_age[i]  = 0;
    end
    dir_fill = 0;
    dir_cap  = CAPACITY_RESET;
  endfunction

  // slot s becomes most recent; valid entries more recent than limit age by one
  function automatic void bump_age(int s, int limit);
    for (int i = 0; i < DIR_DEPTH; i++) begin
      if (i != s && dir_live[i] && dir_age[i] < limit) begin
        dir_age[i]++;
      end
    end
    dir_age[s] = 0;
  endfunction

  function automatic dir_result_t step_directory(cmd_t cmd, logic [KEY_W-1:0] key);
    dir_result_t r;
    int          pick;
    int          best;
    int          eff;
    bit          found;
    r = '0;
    pick = 0;
    best = 0;
    found = 1'b0;
    if (cmd == CMD_LOOKUP) begin
      for (int i = 0; i < DIR_DEPTH; i++) begin
        if (dir_live[i] && dir_key[i] == key && (!found || dir_age[i] < best)) begin
          found = 1'b1;
          best = dir_age[i];
          pick = i;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.slot = pick[SLOT_W-1:0];
        bump_age(pick, best);
      end
    end else begin
      eff = (dir_cap == 0) ? 1 : (dir_cap > DIR_DEPTH) ? DIR_DEPTH : int'(dir_cap);
      if (dir_fill < eff) begin
        for (int i = 0; i < DIR_DEPTH; i++) begin
          if (!found && !dir_live[i]) begin
            found = 1'b1;
            pick = i;
          end
        end
      end
      if (found) begin
        dir_live[pick] = 1'b1;
        dir_key[pick] = key;
        dir_age[pick] = 0;
        bump_age(pick, DIR_DEPTH + 1);
        dir_fill++;
        r.slot = pick[SLOT_W-1:0];
      end else begin
        for (int i = 0; i < DIR_DEPTH; i++) begin
          if (dir_live[i] && (!found || dir_age[i] > best)) begin
            found = 1'b1;
            best = dir_age[i];
            pick = i;
          end
        end
        if (found) begin
          r.evicted = 1'b1;
          r.slot = pick[SLOT_W-1:0];
          dir_key[pick] = key;
          bump_age(pick, DIR_DEPTH + 1);
        end
      end
    end
    r.occ = dir_fill[OCC_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      n_err++;
    end
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic push_req(cmd_t cmd, logic [KEY_W-1:0] key);
    pend_t p;
    p.kind = REQ_ITEM;
    p.cmd = cmd;
    p.key = key;
    p.cap = '0;
    pend_q.push_back(p);
  endtask

  task automatic push_cap(logic [CAP_W-1:0] cap);
    pend_t p;
    p.kind = CAP_WRITE;
    p.cmd = CMD_LOOKUP;
    p.key = '0;
    p.cap = cap;
    pend_q.push_back(p);
  endtask

  task automatic push_drain();
    pend_t p;
    p.kind = DRAIN_WAIT;
    p.cmd = CMD_LOOKUP;
    p.key = '0;
    p.cap = '0;
    pend_q.push_back(p);
  endtask

  // request and capacity-write driver
  always @(posedge clk) begin : drive
    logic             nv;
    logic [KEY_W-1:0] nd;
    logic             nu;
    logic             nwe;
    logic [CAP_W-1:0] nwd;
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      in_tdata    <= '0;
      in_tuser    <= '0;
      cfg_wr_en   <= 1'b0;
      cfg_wr_data <= '0;
      calm        <= 1'b0;
      tx_gap = 0;
      quiet_run = 0;
    end else begin
      nv  = in_tvalid && !in_tready;
      nd  = in_tdata;
      nu  = in_tuser[0];
      nwe = 1'b0;
      nwd = cfg_wr_data;
      quiet_run = (in_tvalid || cfg_wr_en || n_open != 0) ? 0 : quiet_run + 1;
      if (!nv && pend_q.size() > 0) begin
        if (pend_q[0].kind == REQ_ITEM) begin
          if (tx_gap > 0) begin
            tx_gap--;
          end else begin
            nv = 1'b1;
            nd = pend_q[0].key;
            nu = pend_q[0].cmd;
            void'(pend_q.pop_front());
            if (!calm && $urandom_range(0, 4) == 0) begin
              tx_gap = $urandom_range(1, 8);
            end
          end
        end else if (quiet_run >= SETTLE_CYCLES) begin
          if (pend_q[0].kind == CAP_WRITE) begin
            nwe = 1'b1;
            nwd = pend_q[0].cap;
          end
          void'(pend_q.pop_front());
          quiet_run = 0;
        end
      end
      in_tvalid   <= nv;
      in_tdata    <= nd;
      in_tuser    <= nu;
      cfg_wr_en   <= nwe;
      cfg_wr_data <= nwd;
      calm        <= pend_q.size() < 100;
    end
  end

  // result sink stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      rx_stall = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin : watch
    dir_result_t want;
    logic        in_acc;
    logic        out_acc;
    if (!rst_n) begin
      clear_directory();
      n_open <= 0;
    end else begin
      in_acc  = in_tvalid && in_tready;
      out_acc = out_tvalid && out_tready;
      if (cfg_wr_en) begin
        dir_cap = cfg_wr_data;
      end
      if (out_acc) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, out_tdata);
          n_err++;
        end else begin
          want = result_q.pop_front();
          check_field("hit", want.hit, out_tdata[OUT_HIT_POS]);
          check_field("slot", want.slot, out_tdata[OUT_SLOT_LO +: SLOT_W]);
          check_field("evicted", want.evicted, out_tdata[OUT_EVICT_POS]);
          check_field("occupancy", want.occ, out_tdata[OUT_EVICT_POS + 1 +: OCC_W]);
          check_field("pad", 0, out_tdata[OUT_USED_W +: OUT_PAD_W]);
        end
      end
      if (in_acc) begin
        result_q.push_back(step_directory(cmd_t'(in_tuser[0]), in_tdata));
      end
      n_open <= n_open + int'(in_acc) - int'(out_acc);
    end
  end

  initial begin
    #4800000;
    $display("[lru_key_cache_directory_core] ERROR");
    $finish;
  end

  initial begin
    int               sel;
    logic [CAP_W-1:0] cap;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = rand_key();
    end

    // directed: reset capacity, empty lookup, extreme keys, duplicates, eviction
    push_req(CMD_LOOKUP, '0);
    push_req(CMD_INSERT, '0);
    push_req(CMD_INSERT, '1);
    push_req(CMD_INSERT, 64'h8000_0000_0000_0001);
    push_req(CMD_INSERT, '0);
    push_req(CMD_LOOKUP, '0);
    push_req(CMD_LOOKUP, '1);
    push_req(CMD_INSERT, 64'h5555_5555_5555_5555);
    push_req(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    push_req(CMD_LOOKUP, 64'h8000_0000_0000_0001);
    push_drain();
    // zero capacity below occupancy
    push_cap(4'd0);
    push_req(CMD_INSERT, 64'h1234);
    push_req(CMD_LOOKUP, 64'h1234);
    push_req(CMD_LOOKUP, '0);
    // capacity above the directory size
    push_cap(4'd15);
    for (int i = 1; i <= 4; i++) begin
      push_req(CMD_INSERT, 64'(i));
    end
    push_req(CMD_INSERT, 64'd7);
    push_req(CMD_LOOKUP, 64'd7);
    push_req(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          cap = 4'd1;
        end
        1: begin
          cap = 4'd8;
        end
        2: begin
          cap = 4'd0;
        end
        3: begin
          cap = 4'd15;
        end
        4: begin
          cap = 4'd2;
        end
        default: begin
          cap = CAP_W'($urandom_range(0, 15));
        end
      endcase
      push_cap(cap);
      for (int n = 0; n < 60; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          push_req(CMD_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end else if (sel < 55) begin
          push_req(CMD_INSERT, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end else if (sel < 82) begin
          k = rand_key();
          key_pool[$urandom_range(0, POOL_SIZE - 1)] = k;
          push_req(CMD_INSERT, k);
        end else begin
          push_req(CMD_LOOKUP, rand_key());
        end
        if (ph == 6 && n == 30) begin
          push_drain();
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_tvalid || n_open != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (result_q.size() != 0) begin
      $display("%0t: results missing, expected %0d actual 0", $time, result_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("[lru_key_cache_directory_core] OK");
    end else begin
      $display("[lru_key_cache_directory_core] ERROR");
    end
    $finish;
  end

endmodule
